@@ rtl/aabb_affine_transform_core_macros.svh @@
// assertion macros shared by the bounding box transform rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef AABB_AFFINE_TRANSFORM_CORE_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define AABB_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("aabb core: implication check failed");

// next-cycle implication, checked outside reset
`define AABB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("aabb core: next-cycle check failed");

`endif

@@ rtl/aabb_pkg.sv @@
// types and constants for the transformed bounding box core
// no dependencies
package aabb_pkg;

	localparam int AXES      = 3;
	localparam int COORD_W   = 32;
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = COEF_W - 2;
	localparam int MARGIN_W  = 16;
	localparam int ROW_W     = AXES * COEF_W;

	// exact product, sum of three products plus rounding, widened bound
	localparam int PROD_W  = COORD_W + COEF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int BOUND_W = SUM_W - COEF_FRAC + 2;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [BOUND_W-1:0] bound_t;
	typedef logic [ROW_W-1:0]          row_t;

	localparam sum_t ROUND_HALF = sum_t'(1) <<< (COEF_FRAC - 1);

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam bound_t BOUND_HI = bound_t'(COORD_MAX);
	localparam bound_t BOUND_LO = bound_t'(COORD_MIN);

endpackage

@@ rtl/aabb_in_if.sv @@
// box and transform channel, valid/ready handshake
// depends on aabb_pkg
interface aabb_in_if;
	import aabb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t box_min_x;
	coord_t box_min_y;
	coord_t box_min_z;
	coord_t box_max_x;
	coord_t box_max_y;
	coord_t box_max_z;
	row_t   row_x_coeffs;
	row_t   row_y_coeffs;
	row_t   row_z_coeffs;
	coord_t shift_x;
	coord_t shift_y;
	coord_t shift_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output row_x_coeffs, row_y_coeffs, row_z_coeffs, shift_x, shift_y, shift_z,
		input  ready
	);

	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  row_x_coeffs, row_y_coeffs, row_z_coeffs, shift_x, shift_y, shift_z,
		output ready
	);

endinterface

@@ rtl/aabb_out_if.sv @@
// transformed bounds channel, valid/ready handshake
// depends on aabb_pkg
interface aabb_out_if;
	import aabb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_min_x;
	coord_t out_min_y;
	coord_t out_min_z;
	coord_t out_max_x;
	coord_t out_max_y;
	coord_t out_max_z;
	logic   overflow;

	modport source (
		output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		output overflow,
		input  ready
	);

	modport sink (
		input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		input  overflow,
		output ready
	);

endinterface

@@ rtl/aabb_affine_transform_core.sv @@
// top level of the transformed bounding box core, five-stage pipeline
// depends on aabb_pkg, aabb_in_if, aabb_out_if and the assertion macro header
//
// channel   | direction | payload
// ----------+-----------+---------------------------------------------------
// box       | in        | box min/max, three coefficient rows, translation
// result    | out       | widened min/max bounds, overflow
// cfg       | in        | cfg_we, cfg_wdata = margin (reset 1)
//
// one transaction per cycle sustained while the result channel keeps accepting
// stages: 18 coefficient products, per-column min/max pick, row sums,
// rounding with translation and margin, saturation into the output register
// a stall holds each full stage; an empty stage still takes data
// reset empties the pipeline and sets the margin to one
`include "aabb_affine_transform_core_macros.svh"

module aabb_affine_transform_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aabb_pkg::MARGIN_W-1:0] cfg_wdata,
	aabb_in_if.sink                       box,
	aabb_out_if.source                    result
);
	import aabb_pkg::*;

	// margin register
	logic [MARGIN_W-1:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	// unpack the incoming transaction
	coord_t lo_in[AXES];
	coord_t hi_in[AXES];
	coord_t trans_in[AXES];
	row_t   rows_in[AXES];
	coef_t  coef_in[AXES][AXES];

	always_comb begin
		lo_in[0]    = box.box_min_x;
		lo_in[1]    = box.box_min_y;
		lo_in[2]    = box.box_min_z;
		hi_in[0]    = box.box_max_x;
		hi_in[1]    = box.box_max_y;
		hi_in[2]    = box.box_max_z;
		trans_in[0] = box.shift_x;
		trans_in[1] = box.shift_y;
		trans_in[2] = box.shift_z;
		rows_in[0]  = box.row_x_coeffs;
		rows_in[1]  = box.row_y_coeffs;
		rows_in[2]  = box.row_z_coeffs;
		for (int r = 0; r < AXES; r++) begin
			for (int c = 0; c < AXES; c++) begin
				coef_in[r][c] = coef_t'(rows_in[r][c*COEF_W +: COEF_W]);
			end
		end
	end

	// stage valids and ready chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	assign ready_s5  = !valid_s5 || result.ready;
	assign ready_s4  = !valid_s4 || ready_s5;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign box.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= box.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: coefficient times each box bound
	prod_t  plo_s1[AXES][AXES];
	prod_t  phi_s1[AXES][AXES];
	coord_t trans_s1[AXES];

	always_ff @(posedge clk) begin
		if (ready_s1 && box.valid) begin
			for (int r = 0; r < AXES; r++) begin
				trans_s1[r] <= trans_in[r];
				for (int c = 0; c < AXES; c++) begin
					plo_s1[r][c] <= prod_t'(coef_in[r][c]) * prod_t'(lo_in[c]);
					phi_s1[r][c] <= prod_t'(coef_in[r][c]) * prod_t'(hi_in[c]);
				end
			end
		end
	end

	// stage 2: corners are independent per column, so pick min and max per term
	prod_t  pmin_s2[AXES][AXES];
	prod_t  pmax_s2[AXES][AXES];
	coord_t trans_s2[AXES];

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int r = 0; r < AXES; r++) begin
				trans_s2[r] <= trans_s1[r];
				for (int c = 0; c < AXES; c++) begin
					if (plo_s1[r][c] < phi_s1[r][c]) begin
						pmin_s2[r][c] <= plo_s1[r][c];
						pmax_s2[r][c] <= phi_s1[r][c];
					end else begin
						pmin_s2[r][c] <= phi_s1[r][c];
						pmax_s2[r][c] <= plo_s1[r][c];
					end
				end
			end
		end
	end

	// stage 3: row sums with half an lsb for rounding
	sum_t   smin_s3[AXES];
	sum_t   smax_s3[AXES];
	coord_t trans_s3[AXES];

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			for (int r = 0; r < AXES; r++) begin
				trans_s3[r] <= trans_s2[r];
				smin_s3[r]  <= ROUND_HALF + sum_t'(pmin_s2[r][0]) + sum_t'(pmin_s2[r][1])
					+ sum_t'(pmin_s2[r][2]);
				smax_s3[r]  <= ROUND_HALF + sum_t'(pmax_s2[r][0]) + sum_t'(pmax_s2[r][1])
					+ sum_t'(pmax_s2[r][2]);
			end
		end
	end

	// stage 4: drop fraction bits, add translation, widen by the margin
	bound_t blo_s4[AXES];
	bound_t bhi_s4[AXES];
	bound_t margin_ext;

	assign margin_ext = bound_t'(margin_q);

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			for (int r = 0; r < AXES; r++) begin
				blo_s4[r] <= bound_t'(smin_s3[r] >>> COEF_FRAC) + bound_t'(trans_s3[r])
					- margin_ext;
				bhi_s4[r] <= bound_t'(smax_s3[r] >>> COEF_FRAC) + bound_t'(trans_s3[r])
					+ margin_ext;
			end
		end
	end

	// saturation of the six bounds
	coord_t sat_lo[AXES];
	coord_t sat_hi[AXES];
	logic   sat_any;

	always_comb begin
		sat_any = 1'b0;
		for (int r = 0; r < AXES; r++) begin
			if (blo_s4[r] > BOUND_HI) begin
				sat_lo[r] = COORD_MAX;
				sat_any   = 1'b1;
			end else if (blo_s4[r] < BOUND_LO) begin
				sat_lo[r] = COORD_MIN;
				sat_any   = 1'b1;
			end else begin
				sat_lo[r] = blo_s4[r][COORD_W-1:0];
			end
			if (bhi_s4[r] > BOUND_HI) begin
				sat_hi[r] = COORD_MAX;
				sat_any   = 1'b1;
			end else if (bhi_s4[r] < BOUND_LO) begin
				sat_hi[r] = COORD_MIN;
				sat_any   = 1'b1;
			end else begin
				sat_hi[r] = bhi_s4[r][COORD_W-1:0];
			end
		end
	end

	// stage 5: output register
	coord_t lo_s5[AXES];
	coord_t hi_s5[AXES];
	logic   ovf_s5;

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			for (int r = 0; r < AXES; r++) begin
				lo_s5[r] <= sat_lo[r];
				hi_s5[r] <= sat_hi[r];
			end
			ovf_s5 <= sat_any;
		end
	end

	assign result.valid     = valid_s5;
	assign result.out_min_x = lo_s5[0];
	assign result.out_min_y = lo_s5[1];
	assign result.out_min_z = lo_s5[2];
	assign result.out_max_x = hi_s5[0];
	assign result.out_max_y = hi_s5[1];
	assign result.out_max_z = hi_s5[2];
	assign result.overflow  = ovf_s5;

	// any output bound sitting on a range limit
	logic at_limit;

	always_comb begin
		at_limit = 1'b0;
		for (int r = 0; r < AXES; r++) begin
			if (lo_s5[r] == COORD_MAX || lo_s5[r] == COORD_MIN
				|| hi_s5[r] == COORD_MAX || hi_s5[r] == COORD_MIN) begin
				at_limit = 1'b1;
			end
		end
	end

	// output box is ordered on every axis
	logic ordered;

	assign ordered = (lo_s5[0] <= hi_s5[0]) && (lo_s5[1] <= hi_s5[1])
		&& (lo_s5[2] <= hi_s5[2]);

	// checks
	`AABB_ASSERT_IMPLY(a_ovf_at_limit, valid_s5 && ovf_s5, at_limit)
	`AABB_ASSERT_IMPLY(a_not_inverted, valid_s5, ordered)
	`AABB_ASSERT_NEXT(a_stall_holds_s4, valid_s4 && !ready_s5, valid_s4 && valid_s5)
	`AABB_ASSERT_NEXT(a_drain_s3, valid_s3 && ready_s4, valid_s4)

endmodule
